@@ rtl/core/kwm_pkg.sv @@
// Package: shared types, codes and key forming for the k-way merge heap.
package kwm_pkg;

    localparam int unsigned TOTAL_BITS = 22;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

    typedef enum logic [1:0] {
        FN_INSERT  = 2'd0,
        FN_ADVANCE = 2'd1,
        FN_CLEAR   = 2'd2,
        FN_NONE    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        CFG_UNION   = 2'd0,
        CFG_PAIR    = 2'd1,
        CFG_REVERSE = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_LAST_RD,
        ST_DN_RD,
        ST_DN_CMP,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic int_key_mode;
        logic pair_mode;
        logic reverse_order;
    } t_cfg;

    typedef struct packed {
        logic [63:0] key;
        logic [31:0] id;
        logic [31:0] value;
        logic [5:0]  source;
    } t_entry;

    function automatic logic [63:0] form_key(input t_cfg cfg, input logic [31:0] id,
                                             input logic [31:0] val);
        logic [31:0] t;
        logic [31:0] v;
        logic [63:0] k;
        begin
            if (cfg.int_key_mode) begin
                t = cfg.reverse_order ? id : (32'd0 - id);
                k = {{32{t[31]}}, t};
            end else begin
                v = cfg.pair_mode ? val : id;
                k = {v ^ 32'h8000_0000, id ^ 32'h8000_0000};
                if (cfg.reverse_order) begin
                    k = ~k;
                end
            end
            form_key = k;
        end
    endfunction

endpackage

@@ rtl/core/kwm_if.sv @@
// Interfaces: input item channel and result channel.
interface kwm_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic [5:0]         source_id;
    logic signed [31:0] elem_id;
    logic signed [31:0] elem_value;
    logic [15:0]        elem_count;
    modport source (output valid, func, source_id, elem_id, elem_value, elem_count,
                    input ready);
    modport sink (input valid, func, source_id, elem_id, elem_value, elem_count,
                  output ready);
endinterface

interface kwm_out_if;
    logic               valid;
    logic               ready;
    logic               head_valid;
    logic [5:0]         head_source;
    logic signed [31:0] head_id;
    logic signed [31:0] head_value;
    logic [15:0]        head_remaining;
    logic               insert_rejected;
    logic [21:0]        total_elements;
    modport source (output valid, head_valid, head_source, head_id, head_value,
                    head_remaining, insert_rejected, total_elements, input ready);
    modport sink (input valid, head_valid, head_source, head_id, head_value,
                  head_remaining, insert_rejected, total_elements, output ready);
endinterface

@@ rtl/core/kway_merge_heap_core.sv @@
// Top level: k-way merge min-heap with configuration registers.
//
//  channel   dir  transfer when        payload
//  i_in      in   valid & ready        func, source_id, elem_id, elem_value, elem_count
//  o_out     out  valid & ready        head_*, insert_rejected, total_elements
//  i_cfg_*   in   i_cfg_we             register index, one data bit
//
// One item at a time. Clear, rejected inserts and idle advances pass through the
// final state into the result register; an insert or advance sifts one heap level
// per read state and compare state through the entry memory (read, then compare and
// write back). Synchronous reset empties the heap;
// entries are not cleared. A stalled result holds the sequencer at its last step.
module kway_merge_heap_core #(
    parameter int unsigned MAX_SOURCES = 64,
    parameter int unsigned COUNT_BITS  = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [0:0] i_cfg_data,
    kwm_in_if.sink     i_in,
    kwm_out_if.source  o_out
);
    import kwm_pkg::*;

    t_cfg r_cfg;

    // take register writes; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_UNION:   r_cfg.int_key_mode  <= i_cfg_data[0];
                CFG_PAIR:    r_cfg.pair_mode     <= i_cfg_data[0];
                CFG_REVERSE: r_cfg.reverse_order <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    kwm_seq #(.MAX_SOURCES(MAX_SOURCES), .COUNT_BITS(COUNT_BITS)) u_seq (
        .i_clk, .i_rst_n, .i_cfg(r_cfg), .i_in(i_in), .o_out(o_out)
    );

endmodule

@@ rtl/core/kwm_heap_mem.sv @@
// Heap entry memory: one write port, two registered read ports.
module kwm_heap_mem #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned RW    = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  kwm_pkg::t_entry          i_wentry,
    input  logic [RW-1:0]            i_wrem,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output kwm_pkg::t_entry          o_rentry_a,
    output logic [RW-1:0]            o_rrem_a,
    output kwm_pkg::t_entry          o_rentry_b,
    output logic [RW-1:0]            o_rrem_b
);
    import kwm_pkg::*;

    t_entry      ent_mem [DEPTH];
    logic [RW-1:0] rem_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            ent_mem[i_waddr] <= i_wentry;
            rem_mem[i_waddr] <= i_wrem;
        end
        o_rentry_a <= ent_mem[i_raddr_a];
        o_rrem_a   <= rem_mem[i_raddr_a];
        o_rentry_b <= ent_mem[i_raddr_b];
        o_rrem_b   <= rem_mem[i_raddr_b];
    end

endmodule

@@ rtl/core/kwm_seq.sv @@
// Heap sequencer: sift-up, sift-down and result register.
module kwm_seq #(
    parameter int unsigned MAX_SOURCES = 64,
    parameter int unsigned COUNT_BITS  = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  kwm_pkg::t_cfg i_cfg,
    kwm_in_if.sink        i_in,
    kwm_out_if.source     o_out
);
    import kwm_pkg::*;

    localparam int unsigned AW = $clog2(MAX_SOURCES);
    localparam int unsigned PW = $clog2(MAX_SOURCES) + 2;
    localparam logic [PW-1:0] MAXP = PW'(MAX_SOURCES);

    t_state r_state, n_state;
    logic [PW-1:0] r_size, n_size, r_pos, n_pos;
    logic [TOTAL_BITS-1:0] r_total, n_total;
    t_entry r_item, n_item, r_head;
    logic [COUNT_BITS-1:0] r_irem, n_irem, r_hrem;
    logic r_rej, n_rej;

    logic r_ov;
    logic r_o_hv, r_o_rej;
    t_entry r_o_ent;
    logic [15:0] r_o_rem;
    logic [TOTAL_BITS-1:0] r_o_tot;

    logic we;
    logic [AW-1:0] waddr, raddr_a, raddr_b;
    t_entry wentry, rent_a, rent_b;
    logic [COUNT_BITS-1:0] wrem, rrem_a, rrem_b;

    kwm_heap_mem #(.DEPTH(MAX_SOURCES), .RW(COUNT_BITS)) u_mem (
        .i_clk, .i_we(we), .i_waddr(waddr), .i_wentry(wentry), .i_wrem(wrem),
        .i_raddr_a(raddr_a), .i_raddr_b(raddr_b),
        .o_rentry_a(rent_a), .o_rrem_a(rrem_a),
        .o_rentry_b(rent_b), .o_rrem_b(rrem_b)
    );

    logic accept, fin_go, take_b, up_stop, dn_stop;
    logic [COUNT_BITS-1:0] cnt, hrem_dec;
    logic [32:0] sum;
    logic [PW-1:0] pj;
    t_entry new_ent, child;
    logic [COUNT_BITS-1:0] child_rem;

    assign accept   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);
    assign fin_go   = !r_ov || o_out.ready;
    assign cnt      = COUNT_BITS'({16'd0, i_in.elem_count});
    assign hrem_dec = r_hrem - COUNT_BITS'(1);
    assign sum      = 33'(r_total) + 33'(cnt);
    assign pj       = {r_pos[PW-2:0], 1'b0};
    assign take_b   = (pj < r_size) && (rent_b.key < rent_a.key);
    assign child    = take_b ? rent_b : rent_a;
    assign child_rem = take_b ? rrem_b : rrem_a;
    assign up_stop  = rent_a.key <= r_item.key;
    assign dn_stop  = r_item.key <= child.key;

    always_comb begin
        new_ent.key    = form_key(i_cfg, i_in.elem_id, i_in.elem_value);
        new_ent.id     = i_in.elem_id;
        new_ent.value  = i_cfg.pair_mode ? i_in.elem_value : i_in.elem_id;
        new_ent.source = i_in.source_id;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_FIN;
                    if (i_in.func == FN_INSERT) begin
                        if (cnt != '0 && r_size < MAXP) n_state = ST_UP_RD;
                    end else if (i_in.func == FN_ADVANCE && r_size != '0) begin
                        if (hrem_dec != '0) n_state = ST_DN_RD;
                        else if (r_size != PW'(1)) n_state = ST_LAST_RD;
                    end
                end
            end
            ST_UP_RD:   n_state = (r_pos == PW'(1)) ? ST_FIN : ST_UP_CMP;
            ST_UP_CMP:  n_state = up_stop ? ST_FIN : ST_UP_RD;
            ST_LAST_RD: n_state = ST_DN_RD;
            ST_DN_RD:   n_state = (pj > r_size) ? ST_FIN : ST_DN_CMP;
            ST_DN_CMP:  n_state = dn_stop ? ST_FIN : ST_DN_RD;
            ST_FIN:     n_state = fin_go ? ST_IDLE : ST_FIN;
            default:    n_state = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_size  = r_size;
        n_pos   = r_pos;
        n_total = r_total;
        n_item  = r_item;
        n_irem  = r_irem;
        n_rej   = r_rej;
        we      = 1'b0;
        waddr   = AW'(r_pos - PW'(1));
        wentry  = r_item;
        wrem    = r_irem;
        raddr_a = AW'(r_size - PW'(1));
        raddr_b = AW'(pj);
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_rej = 1'b0;
                    if (i_in.func == FN_INSERT) begin
                        if (cnt == '0 || r_size >= MAXP) begin
                            n_rej = 1'b1;
                        end else begin
                            n_total = (sum > 33'(TOTAL_MAX)) ? TOTAL_MAX
                                                             : TOTAL_BITS'(sum);
                            n_size = r_size + PW'(1);
                            n_pos  = r_size + PW'(1);
                            n_item = new_ent;
                            n_irem = cnt;
                        end
                    end else if (i_in.func == FN_ADVANCE && r_size != '0) begin
                        n_pos = PW'(1);
                        if (hrem_dec == '0) begin
                            n_size = r_size - PW'(1);
                        end else begin
                            n_item = new_ent;
                            n_item.source = r_head.source;
                            n_irem = hrem_dec;
                        end
                    end else if (i_in.func == FN_CLEAR) begin
                        n_size  = '0;
                        n_total = '0;
                    end
                end
            end
            ST_UP_RD: begin
                raddr_a = AW'((r_pos >> 1) - PW'(1));
                we = (r_pos == PW'(1));
            end
            ST_UP_CMP: begin
                // hold the item here or move the parent down
                we = 1'b1;
                if (!up_stop) begin
                    wentry = rent_a;
                    wrem   = rrem_a;
                    n_pos  = r_pos >> 1;
                end
            end
            ST_LAST_RD: begin
                n_item = rent_a;
                n_irem = rrem_a;
            end
            ST_DN_RD: begin
                raddr_a = AW'(pj - PW'(1));
                we = (pj > r_size);
            end
            ST_DN_CMP: begin
                we = 1'b1;
                if (!dn_stop) begin
                    wentry = child;
                    wrem   = child_rem;
                    n_pos  = take_b ? pj + PW'(1) : pj;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_size  <= '0;
            r_total <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_size  <= n_size;
            r_total <= n_total;
            if (r_state == ST_FIN && fin_go) r_ov <= 1'b1;
            else if (o_out.ready)            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_item <= n_item;
        r_irem <= n_irem;
        r_rej  <= n_rej;
        if (we && waddr == '0) begin
            r_head <= wentry;
            r_hrem <= wrem;
        end
        if (r_state == ST_FIN && fin_go) begin
            r_o_hv  <= (r_size != '0);
            r_o_ent <= (r_size != '0) ? r_head : '0;
            r_o_rem <= (r_size != '0) ? 16'({16'd0, r_hrem}) : '0;
            r_o_rej <= r_rej;
            r_o_tot <= r_total;
        end
    end

    assign o_out.valid           = r_ov;
    assign o_out.head_valid      = r_o_hv;
    assign o_out.head_source     = r_o_ent.source;
    assign o_out.head_id         = r_o_ent.id;
    assign o_out.head_value      = r_o_ent.value;
    assign o_out.head_remaining  = r_o_rem;
    assign o_out.insert_rejected = r_o_rej;
    assign o_out.total_elements  = r_o_tot;

endmodule

@@ test/kwm_heap_checker.sv @@
// Checker: watches both channels, predicts the merge heap head and compares results.
module kwm_heap_checker
    import kwm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [0:0] i_cfg_data,
    kwm_in_if.sink     i_in,
    kwm_out_if.sink    i_out,
    output int         o_errors,
    output int         o_pending,
    output int         o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        head_valid;
        logic [5:0]  head_source;
        logic [31:0] head_id;
        logic [31:0] head_value;
        logic [15:0] head_remaining;
        logic        insert_rejected;
        logic [21:0] total_elements;
    } t_head_rpt;

    logic [63:0] hk [64];
    logic [31:0] hid [64];
    logic [31:0] hval [64];
    logic [15:0] hrem [64];
    logic [5:0]  hsrc [64];
    int          hsize;
    logic [21:0] total;
    t_cfg        cfg;
    t_head_rpt   head_q [$];

    function automatic logic [63:0] mk_key(logic [31:0] id, logic [31:0] val);
        logic [31:0] t;
        logic [31:0] v;
        logic [63:0] k;
        if (cfg.int_key_mode) begin
            t = cfg.reverse_order ? id : -id;
            k = {{32{t[31]}}, t};
        end else begin
            v = cfg.pair_mode ? val : id;
            k = {v ^ 32'h8000_0000, id ^ 32'h8000_0000};
            if (cfg.reverse_order) k = ~k;
        end
        return k;
    endfunction

    task automatic sink_entry(logic [63:0] k, logic [31:0] id, logic [31:0] val,
                              logic [15:0] rem, logic [5:0] src);
        int i;
        int j;
        i = 1;
        forever begin
            j = i * 2;
            if (j > hsize) break;
            if (j < hsize && hk[j] < hk[j-1]) j++;
            if (k <= hk[j-1]) break;
            hk[i-1] = hk[j-1]; hid[i-1] = hid[j-1]; hval[i-1] = hval[j-1];
            hrem[i-1] = hrem[j-1]; hsrc[i-1] = hsrc[j-1];
            i = j;
        end
        hk[i-1] = k; hid[i-1] = id; hval[i-1] = val; hrem[i-1] = rem; hsrc[i-1] = src;
    endtask

    task automatic predict_head(logic [1:0] fn, logic [5:0] src, logic [31:0] id,
                                logic [31:0] vin, logic [15:0] cnt);
        t_head_rpt r;
        logic [31:0] val;
        logic [15:0] rem;
        logic [63:0] k;
        int i;
        int j;
        int last;
        r = '0;
        val = cfg.pair_mode ? vin : id;
        case (fn)
            FN_INSERT: begin
                if (cnt == 0 || hsize >= 64) begin
                    r.insert_rejected = 1'b1;
                end else begin
                    total = (23'(total) + cnt > 23'(TOTAL_MAX)) ? TOTAL_MAX : total + cnt;
                    k = mk_key(id, vin);
                    hsize++;
                    i = hsize;
                    while (i > 1) begin
                        j = i >> 1;
                        if (hk[j-1] <= k) break;
                        hk[i-1] = hk[j-1]; hid[i-1] = hid[j-1]; hval[i-1] = hval[j-1];
                        hrem[i-1] = hrem[j-1]; hsrc[i-1] = hsrc[j-1];
                        i = j;
                    end
                    hk[i-1] = k; hid[i-1] = id; hval[i-1] = val;
                    hrem[i-1] = cnt; hsrc[i-1] = src;
                end
            end
            FN_ADVANCE: begin
                if (hsize > 0) begin
                    rem = hrem[0] - 16'd1;
                    if (rem == 0) begin
                        last = hsize - 1;
                        hsize--;
                        if (hsize > 0)
                            sink_entry(hk[last], hid[last], hval[last], hrem[last],
                                       hsrc[last]);
                    end else begin
                        sink_entry(mk_key(id, vin), id, val, rem, hsrc[0]);
                    end
                end
            end
            FN_CLEAR: begin
                hsize = 0;
                total = '0;
            end
            default: ;
        endcase
        if (hsize > 0) begin
            r.head_valid = 1'b1;
            r.head_source = hsrc[0];
            r.head_id = hid[0];
            r.head_value = hval[0];
            r.head_remaining = hrem[0];
        end
        r.total_elements = total;
        head_q.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_head_rpt got;
        t_head_rpt exp;
        if (!i_rst_n) begin
            hsize = 0;
            total = '0;
            cfg = '0;
            head_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_UNION:   cfg.int_key_mode = i_cfg_data[0];
                    CFG_PAIR:    cfg.pair_mode = i_cfg_data[0];
                    CFG_REVERSE: cfg.reverse_order = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                got = {i_out.head_valid, i_out.head_source, i_out.head_id,
                       i_out.head_value, i_out.head_remaining, i_out.insert_rejected,
                       i_out.total_elements};
                o_results++;
                if (head_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    o_errors++;
                end else begin
                    exp = head_q.pop_front();
                    if (got !== exp) begin
                        $display("%0t: mismatch expected %h actual %h", $time, exp, got);
                        o_errors++;
                    end
                end
            end
            if (i_in.valid && i_in.ready)
                predict_head(i_in.func, i_in.source_id, i_in.elem_id, i_in.elem_value,
                             i_in.elem_count);
        end
        o_pending = head_q.size();
    end

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_results = 0;
    end
endmodule

@@ test/kway_merge_heap_core_tb.sv @@
// Testbench top: drives stimulus into the merge heap core and reports the verdict.
module kway_merge_heap_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import kwm_pkg::*;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_idx = CFG_UNION;
    logic [0:0] cfg_data = 1'b0;
    int         errors;
    int         pending;
    int         results;
    int         idle_in;
    int         stall_out;
    int         items_sent;
    int         live_srcs;

    kwm_in_if  in_ch ();
    kwm_out_if out_ch ();

    kway_merge_heap_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    kwm_heap_checker u_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .i_out      (out_ch),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_results  (results)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.func = FN_NONE;
        in_ch.source_id = '0;
        in_ch.elem_id = '0;
        in_ch.elem_value = '0;
        in_ch.elem_count = '0;
        out_ch.ready = 1'b0;
    end

    // Receiver: stall at the current phase's percentage, redrawn every cycle.
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= stall_out);
    end

    // Send one item: drop valid for an optional idle gap, then hold it until the transfer.
    task automatic send_item(logic [1:0] fn, logic [5:0] src, logic [31:0] id,
                             logic [31:0] val, logic [15:0] cnt);
        if ($urandom_range(99) < idle_in) begin
            in_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_in);
        end
        in_ch.valid <= 1'b1;
        in_ch.func <= fn;
        in_ch.source_id <= src;
        in_ch.elem_id <= id;
        in_ch.elem_value <= val;
        in_ch.elem_count <= cnt;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
        if (fn == FN_INSERT && cnt != 0 && live_srcs < 64) live_srcs++;
        if (fn == FN_CLEAR) live_srcs = 0;
    endtask

    // Drain all expected results, then let the core settle before reconfiguring.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || in_ch.valid);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_cfg(t_cfg c);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_UNION;
        cfg_data <= c.int_key_mode;
        @(posedge i_clk);
        cfg_idx <= CFG_PAIR;
        cfg_data <= c.pair_mode;
        @(posedge i_clk);
        cfg_idx <= CFG_REVERSE;
        cfg_data <= c.reverse_order;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_int();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(7) - 3;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_cnt();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'hffff;
            2: return 16'($urandom);
            default: return 16'($urandom_range(6, 1));
        endcase
    endfunction

    // Mostly merge traffic: fill with sources, advance through them; rare clears.
    task automatic run_random(int n);
        int pick;
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 2)
                send_item(FN_CLEAR, 6'($urandom), rand_int(), rand_int(), 16'($urandom));
            else if (pick < 4)
                send_item(FN_NONE, 6'($urandom), rand_int(), rand_int(), 16'($urandom));
            else if (pick < 40 || live_srcs == 0)
                send_item(FN_INSERT, 6'($urandom), rand_int(), rand_int(), rand_cnt());
            else
                send_item(FN_ADVANCE, 6'($urandom), rand_int(), rand_int(),
                          16'($urandom));
        end
    endtask

    initial begin
        t_cfg c;
        items_sent = 0;
        live_srcs = 0;
        idle_in = 0;
        stall_out = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, every function, empty advance, count exhaustion.
        c = '0;
        write_cfg(c);
        send_item(FN_ADVANCE, 6'd0, 32'd5, 32'd0, 16'd0);
        send_item(FN_INSERT, 6'd3, 32'd7, 32'd1, 16'd0);
        send_item(FN_INSERT, 6'd63, 32'h7fff_ffff, 32'h8000_0000, 16'hffff);
        send_item(FN_INSERT, 6'd0, 32'h8000_0000, 32'h7fff_ffff, 16'd1);
        send_item(FN_INSERT, 6'd21, 32'hffff_ffff, 32'd0, 16'd2);
        send_item(FN_ADVANCE, 6'd0, 32'd9, 32'd9, 16'd0);
        send_item(FN_ADVANCE, 6'd0, 32'd100, 32'd4, 16'd0);
        send_item(FN_ADVANCE, 6'd0, 32'd200, 32'd4, 16'd0);
        send_item(FN_NONE, 6'h2a, 32'h5555_5555, 32'haaaa_aaaa, 16'h5555);
        send_item(FN_CLEAR, 6'd0, 32'd0, 32'd0, 16'd0);
        send_item(FN_ADVANCE, 6'd0, 32'd1, 32'd1, 16'd0);
        // Drive the total near its maximum and overfill the heap.
        repeat (66) send_item(FN_INSERT, 6'($urandom), $urandom, $urandom, 16'hffff);
        send_item(FN_CLEAR, 6'd0, 32'd0, 32'd0, 16'd0);
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            c = t_cfg'(3'(ph));
            write_cfg(c);
            case (ph % 4)
                0: begin idle_in = 0;  stall_out = 0;  end
                1: begin idle_in = 51; stall_out = 0;  end
                2: begin idle_in = 0;  stall_out = 51; end
                default: begin idle_in = 7; stall_out = 7; end
            endcase
            run_random(225);
            wait_idle();
        end
        $display("Covered %0d items and %0d results over all eight mode settings",
                 items_sent, results);
        if (errors == 0)
            $display("kway_merge_heap_core_tb: clean");
        else
            $display("kway_merge_heap_core_tb: errors");
        $finish;
    end

    initial begin
        #20ms;
        $display("kway_merge_heap_core_tb: errors");
        $finish;
    end
endmodule
